[rtl/zbpa_pkg.sv]
// shared types, codes and helpers of the zoned buddy page allocator
package zbpa_pkg;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_DONATE = 2'd2;
    localparam logic [1:0] CMD_STATS  = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [1:0] ZONE_LOW  = 2'd0;
    localparam logic [1:0] ZONE_TOP  = 2'd2;
    localparam logic [1:0] ZONE_NONE = 2'd3;

    localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_DMA_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_DMA32_LIMIT = 2'd2;

    localparam logic [4:0]  TAG_NONE        = 5'd31;
    localparam logic [16:0] DMA_LIMIT_RST   = 17'd4096;
    localparam logic [16:0] DMA32_LIMIT_RST = 17'd65536;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_STAT,
        S_ARD,
        S_ACHK,
        S_APOP,
        S_SPLIT,
        S_MARK,
        S_FSTEP,
        S_FTAG,
        S_FLST,
        S_FWALK,
        S_PRD,
        S_PWR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        tag_re;
        logic [16:0] tag_raddr;
        logic        tag_we;
        logic [16:0] tag_waddr;
        logic [4:0]  tag_wdata;
        logic        link_re;
        logic [16:0] link_raddr;
        logic        link_we;
        logic [16:0] link_waddr;
        logic [15:0] link_wdata;
    } frm_req_t;

    function automatic logic [1:0] zone_of(input logic [16:0] f, input logic [16:0] fc,
                                           input logic [16:0] dl, input logic [16:0] d32);
        logic [1:0] z;
        if (f >= fc)
            z = ZONE_NONE;
        else if (f < dl)
            z = ZONE_LOW;
        else if (f < d32)
            z = 2'd1;
        else
            z = ZONE_TOP;
        return z;
    endfunction

endpackage

[rtl/zbpa_frame_store.sv]
// per-frame tag and link memories with the tag clearing pass after reset
module zbpa_frame_store
    import zbpa_pkg::*;
#(
    parameter int FRAMES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  frm_req_t    req,
    output logic [4:0]  tag_rdata,
    output logic [15:0] link_rdata,
    output logic        busy
);

    localparam int FIW = $clog2(FRAMES);

    logic [4:0]     tag_mem [FRAMES];
    logic [15:0]    link_mem [FRAMES];
    logic [FIW-1:0] clr_cnt_reg;
    logic           busy_reg;
    logic [4:0]     tag_rd_reg;
    logic [15:0]    link_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + FIW'(1);
            if (clr_cnt_reg == FIW'(FRAMES - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            tag_mem[clr_cnt_reg] <= TAG_NONE;
        else if (req.tag_we)
            tag_mem[FIW'(req.tag_waddr)] <= req.tag_wdata;
        if (req.tag_re)
            tag_rd_reg <= tag_mem[FIW'(req.tag_raddr)];
    end

    always_ff @(posedge clk)
    begin
        if (req.link_we)
            link_mem[FIW'(req.link_waddr)] <= req.link_wdata;
        if (req.link_re)
            link_rd_reg <= link_mem[FIW'(req.link_raddr)];
    end

    assign tag_rdata  = tag_rd_reg;
    assign link_rdata = link_rd_reg;
    assign busy       = busy_reg;

endmodule

[rtl/zoned_buddy_page_allocator.sv]
// top level: command sequencer, free list memory and zone counters
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: cmd, frame_num, order_req, zone_sel
// m        out  m_tvalid/m_tready  m_tdata: status, frame_out, order_count,
//                                           zone_free, zone_managed
// cfg      in   cfg_we             cfg_index, cfg_data
//
// one request at a time; rejects go from S_DISPATCH to S_DONE, stats pass through S_STAT
// alloc: S_ARD, S_ACHK per order scanned; S_SPLIT, S_PRD, S_PWR per split; S_MARK per frame
// free: S_FSTEP/S_FTAG/S_FLST per merge level, S_FWALK per entry walked, S_PRD/S_PWR to push
// after reset the tag memory clearing pass writes all FRAMES tags with s_tready low
// a finished result waits in the output register while the next request runs
module zoned_buddy_page_allocator
    import zbpa_pkg::*;
#(
    parameter int ORDER_TOP = 10,
    parameter int FRAMES    = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cmd, frame_num, order_req, zone_sel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // status, frame_out, order_count, zone_free, zone_managed
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int NO = ORDER_TOP + 1;
    localparam int NL = 3 * NO;
    localparam int LW = $clog2(NL);
    localparam logic [3:0] MAXO = 4'(ORDER_TOP);

    state_t state_reg, state_next;

    logic [1:0]  cmd_reg, zsel_reg;
    logic [15:0] fnum_reg;
    logic [3:0]  ordq_reg;

    logic [1:0]  zn_reg, zn_next;
    logic [16:0] fr_reg, fr_next;
    logic [3:0]  od_reg, od_next;
    logic [16:0] pf_reg, pf_next;
    logic [3:0]  po_reg, po_next;
    logic [15:0] prev_reg, prev_next;
    logic [15:0] cur_reg, cur_next;
    logic [16:0] k_reg, k_next;
    logic [15:0] mk_reg, mk_next;

    logic [16:0] fpz_reg [3];
    logic [16:0] fpz_next [3];
    logic [16:0] mpz_reg [3];
    logic [16:0] mpz_next [3];

    logic [16:0] fc_reg, dl_reg, d32_reg;

    logic [1:0]  rs_status_reg, rs_status_next;
    logic [15:0] rs_frame_reg, rs_frame_next;
    logic [16:0] rs_ocnt_reg, rs_ocnt_next;
    logic [16:0] rs_zfree_reg, rs_zfree_next;
    logic [16:0] rs_zman_reg, rs_zman_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;

    // free list heads and lengths
    logic [32:0]   lst_mem [NL];
    logic [NL-1:0] lst_vld_reg;
    logic [32:0]   lst_rd_reg;
    logic          lst_rv_reg;
    logic          lst_re, lst_we;
    logic [LW-1:0] lst_raddr, lst_waddr;
    logic [32:0]   lst_wdata;
    logic [15:0]   lst_head;
    logic [16:0]   lst_cnt;

    frm_req_t    frm_req;
    logic [4:0]  tag_rdata;
    logic [15:0] link_rdata;
    logic        clr_busy;

    logic [16:0] span_q, span_od, buddy, last_frame;
    logic [1:0]  fz, lz, zq;

    function automatic logic [LW-1:0] lidx(input logic [1:0] z, input logic [3:0] o);
        return LW'(int'(z) * NO + int'(o));
    endfunction

    zbpa_frame_store #(
        .FRAMES(FRAMES)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (frm_req),
        .tag_rdata  (tag_rdata),
        .link_rdata (link_rdata),
        .busy       (clr_busy)
    );

    assign lst_head = lst_rv_reg ? lst_rd_reg[32:17] : 16'd0;
    assign lst_cnt  = lst_rv_reg ? lst_rd_reg[16:0] : 17'd0;

    assign span_q     = 17'd1 << ordq_reg;
    assign span_od    = 17'd1 << od_reg;
    assign buddy      = fr_reg ^ span_od;
    assign last_frame = {1'b0, fnum_reg} + span_q - 17'd1;
    assign fz         = zone_of({1'b0, fnum_reg}, fc_reg, dl_reg, d32_reg);
    assign lz         = zone_of(last_frame, fc_reg, dl_reg, d32_reg);
    assign zq         = (zsel_reg == ZONE_NONE) ? ZONE_TOP : zsel_reg;

    assign s_tready = (state_reg == S_IDLE) && !clr_busy;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= '0;
            dl_reg  <= DMA_LIMIT_RST;
            d32_reg <= DMA32_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT: fc_reg  <= cfg_data;
                CFG_DMA_LIMIT:   dl_reg  <= cfg_data;
                CFG_DMA32_LIMIT: d32_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tdata[1:0];
            fnum_reg <= s_tdata[17:2];
            ordq_reg <= s_tdata[21:18];
            zsel_reg <= s_tdata[23:22];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lst_we)
            lst_mem[lst_waddr] <= lst_wdata;
        if (lst_re)
            lst_rd_reg <= lst_mem[lst_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lst_vld_reg <= '0;
            lst_rv_reg  <= 1'b0;
        end
        else
        begin
            if (lst_we)
                lst_vld_reg[lst_waddr] <= 1'b1;
            if (lst_re)
                lst_rv_reg <= lst_vld_reg[lst_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                fpz_reg[j] <= '0;
                mpz_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            for (int j = 0; j < 3; j++)
            begin
                fpz_reg[j] <= fpz_next[j];
                mpz_reg[j] <= mpz_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        zn_reg        <= zn_next;
        fr_reg        <= fr_next;
        od_reg        <= od_next;
        pf_reg        <= pf_next;
        po_reg        <= po_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        mk_reg        <= mk_next;
        rs_status_reg <= rs_status_next;
        rs_frame_reg  <= rs_frame_next;
        rs_ocnt_reg   <= rs_ocnt_next;
        rs_zfree_reg  <= rs_zfree_next;
        rs_zman_reg   <= rs_zman_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        zn_next        = zn_reg;
        fr_next        = fr_reg;
        od_next        = od_reg;
        pf_next        = pf_reg;
        po_next        = po_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        mk_next        = mk_reg;
        rs_status_next = rs_status_reg;
        rs_frame_next  = rs_frame_reg;
        rs_ocnt_next   = rs_ocnt_reg;
        rs_zfree_next  = rs_zfree_reg;
        rs_zman_next   = rs_zman_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        for (int j = 0; j < 3; j++)
        begin
            fpz_next[j] = fpz_reg[j];
            mpz_next[j] = mpz_reg[j];
        end
        lst_re    = 1'b0;
        lst_raddr = lidx(zn_reg, od_reg);
        lst_we    = 1'b0;
        lst_waddr = lidx(zn_reg, od_reg);
        lst_wdata = {lst_head, lst_cnt};
        frm_req   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                    state_next = S_DISPATCH;
            end

            S_DISPATCH:
            begin
                rs_status_next = ST_REJECT;
                rs_frame_next  = '0;
                rs_ocnt_next   = '0;
                rs_zfree_next  = '0;
                rs_zman_next   = '0;
                state_next     = S_DONE;
                if (ordq_reg <= MAXO)
                begin
                    unique case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            zn_next    = zq;
                            od_next    = ordq_reg;
                            state_next = S_ARD;
                        end
                        CMD_FREE:
                        begin
                            if (fz != ZONE_NONE)
                            begin
                                zn_next      = fz;
                                fr_next      = {1'b0, fnum_reg};
                                od_next      = ordq_reg;
                                fpz_next[fz] = fpz_reg[fz] + span_q;
                                state_next   = S_FSTEP;
                            end
                        end
                        CMD_DONATE:
                        begin
                            if (fz != ZONE_NONE && (fnum_reg & span_q[15:0] - 16'd1) == 16'd0
                                && lz == fz)
                            begin
                                zn_next      = fz;
                                pf_next      = {1'b0, fnum_reg};
                                po_next      = ordq_reg;
                                fpz_next[fz] = fpz_reg[fz] + span_q;
                                mpz_next[fz] = mpz_reg[fz] + span_q;
                                state_next   = S_PRD;
                            end
                        end
                        CMD_STATS:
                        begin
                            lst_re     = 1'b1;
                            lst_raddr  = lidx(zq, ordq_reg);
                            state_next = S_STAT;
                        end
                        default: ;
                    endcase
                end
            end

            S_STAT:
            begin
                rs_status_next = ST_DONE;
                rs_ocnt_next   = lst_cnt;
                rs_zfree_next  = fpz_reg[zq];
                rs_zman_next   = mpz_reg[zq];
                state_next     = S_DONE;
            end

            // alloc: scan orders upward, then zones downward
            S_ARD:
            begin
                lst_re     = 1'b1;
                state_next = S_ACHK;
            end

            S_ACHK:
            begin
                if (lst_cnt == 17'd0)
                begin
                    if (od_reg == MAXO)
                    begin
                        if (zn_reg == ZONE_LOW)
                        begin
                            rs_status_next = ST_EMPTY;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            zn_next    = zn_reg - 2'd1;
                            od_next    = ordq_reg;
                            state_next = S_ARD;
                        end
                    end
                    else
                    begin
                        od_next    = od_reg + 4'd1;
                        state_next = S_ARD;
                    end
                end
                else
                begin
                    fr_next            = {1'b0, lst_head};
                    frm_req.link_re    = 1'b1;
                    frm_req.link_raddr = {1'b0, lst_head};
                    state_next         = S_APOP;
                end
            end

            S_APOP:
            begin
                lst_we     = 1'b1;
                lst_wdata  = {link_rdata, lst_cnt - 17'd1};
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                if (od_reg > ordq_reg)
                begin
                    od_next    = od_reg - 4'd1;
                    po_next    = od_reg - 4'd1;
                    pf_next    = fr_reg + (17'd1 << (od_reg - 4'd1));
                    state_next = S_PRD;
                end
                else
                begin
                    mk_next          = '0;
                    fpz_next[zn_reg] = fpz_reg[zn_reg] - span_q;
                    state_next       = S_MARK;
                end
            end

            S_MARK:
            begin
                frm_req.tag_we    = 1'b1;
                frm_req.tag_waddr = fr_reg + {1'b0, mk_reg};
                frm_req.tag_wdata = TAG_NONE;
                mk_next           = mk_reg + 16'd1;
                if ({1'b0, mk_reg} == span_q - 17'd1)
                begin
                    rs_status_next = ST_DONE;
                    rs_frame_next  = fr_reg[15:0];
                    state_next     = S_DONE;
                end
            end

            // free: merge with the buddy while possible
            S_FSTEP:
            begin
                pf_next = fr_reg;
                po_next = od_reg;
                if (od_reg < MAXO &&
                    zone_of(buddy, fc_reg, dl_reg, d32_reg) == zn_reg)
                begin
                    frm_req.tag_re    = 1'b1;
                    frm_req.tag_raddr = buddy;
                    state_next        = S_FTAG;
                end
                else
                    state_next = S_PRD;
            end

            S_FTAG:
            begin
                if (tag_rdata == {1'b0, od_reg})
                begin
                    lst_re     = 1'b1;
                    state_next = S_FLST;
                end
                else
                    state_next = S_PRD;
            end

            S_FLST:
            begin
                cur_next = lst_head;
                k_next   = '0;
                if (lst_cnt == 17'd0)
                    state_next = S_PRD;
                else
                begin
                    frm_req.link_re    = 1'b1;
                    frm_req.link_raddr = {1'b0, lst_head};
                    state_next         = S_FWALK;
                end
            end

            S_FWALK:
            begin
                if ({1'b0, cur_reg} == buddy)
                begin
                    lst_we = 1'b1;
                    if (k_reg == 17'd0)
                        lst_wdata = {link_rdata, lst_cnt - 17'd1};
                    else
                    begin
                        lst_wdata          = {lst_head, lst_cnt - 17'd1};
                        frm_req.link_we    = 1'b1;
                        frm_req.link_waddr = {1'b0, prev_reg};
                        frm_req.link_wdata = link_rdata;
                    end
                    if (buddy < fr_reg)
                        fr_next = buddy;
                    od_next    = od_reg + 4'd1;
                    state_next = S_FSTEP;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    k_next    = k_reg + 17'd1;
                    if (k_reg + 17'd1 == lst_cnt)
                        state_next = S_PRD;
                    else
                    begin
                        frm_req.link_re    = 1'b1;
                        frm_req.link_raddr = {1'b0, link_rdata};
                    end
                end
            end

            // push pf_reg at order po_reg onto the list of zone zn_reg
            S_PRD:
            begin
                lst_re     = 1'b1;
                lst_raddr  = lidx(zn_reg, po_reg);
                state_next = S_PWR;
            end

            S_PWR:
            begin
                lst_we             = 1'b1;
                lst_waddr          = lidx(zn_reg, po_reg);
                lst_wdata          = {pf_reg[15:0], lst_cnt + 17'd1};
                frm_req.link_we    = 1'b1;
                frm_req.link_waddr = pf_reg;
                frm_req.link_wdata = lst_head;
                frm_req.tag_we     = 1'b1;
                frm_req.tag_waddr  = pf_reg;
                frm_req.tag_wdata  = {1'b0, po_reg};
                if (cmd_reg == CMD_ALLOC)
                    state_next = S_SPLIT;
                else
                begin
                    rs_status_next = ST_DONE;
                    state_next     = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, rs_zman_reg, rs_zfree_reg, rs_ocnt_reg,
                                     rs_frame_reg, rs_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s_tready)
        else $error("request accepted during tag clearing");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_DISPATCH)
        else $error("accepted request not dispatched");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("illegal status code");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && m_tvalid_reg && !m_tready |=> state_reg == S_DONE)
        else $error("result dropped while output busy");
`endif

endmodule

[sim/testbench.sv]
// self-checking testbench for the zoned buddy page allocator
module testbench
    import zbpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORD = 10;
    localparam int NFRAMES = 65536;
    localparam int NLISTS  = 3 * (MAX_ORD + 1);

    typedef struct packed {
        logic [1:0]  zone_sel;
        logic [3:0]  order_req;
        logic [15:0] frame_num;
        logic [1:0]  cmd;
    } page_req_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic [16:0] zone_managed;
        logic [16:0] zone_free;
        logic [16:0] order_count;
        logic [15:0] frame_out;
        logic [1:0]  status;
    } page_rsp_t;

    typedef struct {
        logic [15:0] frame;
        logic [3:0]  order;
    } live_block_t;

    class page_scoreboard;
        logic [4:0]  tag_mem[NFRAMES];
        logic [15:0] link_mem[NFRAMES];
        logic [15:0] head_mem[NLISTS];
        logic [16:0] count_mem[NLISTS];
        logic [16:0] free_cnt[3];
        logic [16:0] managed_frames[3];
        int unsigned frame_limit, low_end, mid_end;
        page_rsp_t   rsp_q[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < NFRAMES; i++)
            begin
                tag_mem[i] = TAG_NONE;
                link_mem[i] = '0;
            end
            for (int i = 0; i < NLISTS; i++)
            begin
                head_mem[i] = '0;
                count_mem[i] = '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                free_cnt[i] = '0;
                managed_frames[i] = '0;
            end
            frame_limit = 0;
            low_end = DMA_LIMIT_RST;
            mid_end = DMA32_LIMIT_RST;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] val);
            if (idx == CFG_FRAME_COUNT)
                frame_limit = val;
            else if (idx == CFG_DMA_LIMIT)
                low_end = val;
            else if (idx == CFG_DMA32_LIMIT)
                mid_end = val;
        endfunction

        function int unsigned zone_for(int unsigned f);
            if (f >= frame_limit)
                return ZONE_NONE;
            if (f < low_end)
                return ZONE_LOW;
            if (f < mid_end)
                return 1;
            return ZONE_TOP;
        endfunction

        function void push_list(int unsigned z, int unsigned f, int unsigned o);
            int unsigned li;
            li = z * (MAX_ORD + 1) + o;
            link_mem[f % NFRAMES] = head_mem[li];
            head_mem[li] = f[15:0];
            count_mem[li] = count_mem[li] + 17'd1;
            tag_mem[f % NFRAMES] = o[4:0];
        endfunction

        function bit unlink(int unsigned z, int unsigned f, int unsigned o);
            int unsigned li, cur, prv, nx;
            logic [16:0] n;
            li = z * (MAX_ORD + 1) + o;
            n = count_mem[li];
            cur = head_mem[li];
            prv = 0;
            for (int unsigned k = 0; k < n; k++)
            begin
                nx = link_mem[cur % NFRAMES];
                if (cur == f)
                begin
                    if (k == 0)
                        head_mem[li] = nx[15:0];
                    else
                        link_mem[prv % NFRAMES] = nx[15:0];
                    count_mem[li] = n - 17'd1;
                    return 1;
                end
                prv = cur;
                cur = nx;
            end
            return 0;
        endfunction

        function bit take_block(int unsigned z, int unsigned ord, output int unsigned f);
            int unsigned o, li, span;
            o = ord;
            while (o <= MAX_ORD && count_mem[z * (MAX_ORD + 1) + o] == 0)
                o++;
            if (o > MAX_ORD)
                return 0;
            li = z * (MAX_ORD + 1) + o;
            f = head_mem[li];
            head_mem[li] = link_mem[f % NFRAMES];
            count_mem[li] = count_mem[li] - 17'd1;
            while (o > ord)
            begin
                o--;
                push_list(z, f + (1 << o), o);
            end
            span = 1 << ord;
            for (int unsigned i = 0; i < span; i++)
                tag_mem[(f + i) % NFRAMES] = TAG_NONE;
            free_cnt[z] = free_cnt[z] - span[16:0];
            return 1;
        endfunction

        function void give_back(int unsigned z, int unsigned f, int unsigned o);
            int unsigned b;
            free_cnt[z] = free_cnt[z] + (17'd1 << o);
            while (o < MAX_ORD)
            begin
                b = f ^ (1 << o);
                if (zone_for(b) != z)
                    break;
                if (tag_mem[b % NFRAMES] != o)
                    break;
                if (!unlink(z, b, o))
                    break;
                if (b < f)
                    f = b;
                o++;
            end
            push_list(z, f, o);
        endfunction

        // apply one accepted request and queue its expected response
        function page_rsp_t note_request(page_req_t r);
            page_rsp_t e;
            int unsigned z, fz, f, sz;
            e = '0;
            e.status = ST_REJECT;
            z = (r.zone_sel > 2) ? 2 : r.zone_sel;
            if (r.order_req <= MAX_ORD)
            begin
                case (r.cmd)
                    CMD_ALLOC:
                    begin
                        e.status = ST_EMPTY;
                        for (int i = z; i >= 0; i--)
                            if (take_block(i, r.order_req, f))
                            begin
                                e.status = ST_DONE;
                                e.frame_out = f[15:0];
                                break;
                            end
                    end
                    CMD_FREE:
                    begin
                        fz = zone_for(r.frame_num);
                        if (fz < 3)
                        begin
                            give_back(fz, r.frame_num, r.order_req);
                            e.status = ST_DONE;
                        end
                    end
                    CMD_DONATE:
                    begin
                        fz = zone_for(r.frame_num);
                        sz = 1 << r.order_req;
                        if (fz < 3 && (r.frame_num & (sz - 1)) == 0 &&
                            zone_for(r.frame_num + sz - 1) == fz)
                        begin
                            push_list(fz, r.frame_num, r.order_req);
                            free_cnt[fz] = free_cnt[fz] + sz[16:0];
                            managed_frames[fz] = managed_frames[fz] + sz[16:0];
                            e.status = ST_DONE;
                        end
                    end
                    default:
                    begin
                        e.order_count = count_mem[z * (MAX_ORD + 1) + r.order_req];
                        e.zone_free = free_cnt[z];
                        e.zone_managed = managed_frames[z];
                        e.status = ST_DONE;
                    end
                endcase
            end
            rsp_q.push_back(e);
            return e;
        endfunction

        function void check_response(page_rsp_t a);
            page_rsp_t e;
            checked++;
            if (rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
                return;
            end
            e = rsp_q.pop_front();
            if (a.status !== e.status)
                $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            if (a.frame_out !== e.frame_out)
                $display("%0t: frame_out exp %0d got %0d", $time, e.frame_out, a.frame_out);
            if (a.order_count !== e.order_count)
                $display("%0t: order_count exp %0d got %0d", $time, e.order_count,
                         a.order_count);
            if (a.zone_free !== e.zone_free)
                $display("%0t: zone_free exp %0d got %0d", $time, e.zone_free, a.zone_free);
            if (a.zone_managed !== e.zone_managed)
                $display("%0t: zone_managed exp %0d got %0d", $time, e.zone_managed,
                         a.zone_managed);
            if (a.pad !== 3'b000)
                $display("%0t: pad exp 0 got %0d", $time, a.pad);
            if (a.status !== e.status || a.frame_out !== e.frame_out ||
                a.order_count !== e.order_count || a.zone_free !== e.zone_free ||
                a.zone_managed !== e.zone_managed || a.pad !== 3'b000)
                errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    page_scoreboard sb;
    live_block_t    live_q[$];
    int             tx_idle;
    int             rx_idle;
    int             sent;

    zoned_buddy_page_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_response(page_rsp_t'(m_tdata));
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(logic [1:0] cmd, logic [15:0] fr, logic [3:0] ord,
                                logic [1:0] zs);
        page_req_t r;
        page_rsp_t e;
        live_block_t lb;
        r.cmd = cmd;
        r.frame_num = fr;
        r.order_req = ord;
        r.zone_sel = zs;
        s_tvalid <= 1'b1;
        s_tdata <= r;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        e = sb.note_request(r);
        sent++;
        if (cmd == CMD_ALLOC && e.status == ST_DONE)
        begin
            lb.frame = e.frame_out;
            lb.order = ord;
            live_q.push_back(lb);
        end
        if ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            while ($urandom_range(99) < tx_idle)
                @(posedge clk);
            @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.rsp_q.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic set_zones(logic [16:0] fc, logic [16:0] dl, logic [16:0] d32);
        write_reg(CFG_FRAME_COUNT, fc);
        write_reg(CFG_DMA_LIMIT, dl);
        write_reg(CFG_DMA32_LIMIT, d32);
        live_q.delete();
    endtask

    task automatic random_requests(int n);
        int unsigned pick, o, idx, fc;
        live_block_t lb;
        fc = sb.frame_limit;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            o = ($urandom_range(3) == 0) ? $urandom_range(MAX_ORD) : $urandom_range(3);
            if (pick < 25 && fc > 0)
                send_request(CMD_DONATE, 16'(($urandom_range(fc - 1) >> o) << o), 4'(o),
                             2'($urandom_range(3)));
            else if (pick < 55)
                send_request(CMD_ALLOC, 16'($urandom), 4'(o), 2'($urandom_range(3)));
            else if (pick < 80 && live_q.size() > 0)
            begin
                idx = $urandom_range(live_q.size() - 1);
                lb = live_q[idx];
                live_q.delete(idx);
                send_request(CMD_FREE, lb.frame, lb.order, 2'($urandom_range(3)));
            end
            else if (pick < 90)
                send_request(CMD_STATS, 16'($urandom), 4'($urandom_range(MAX_ORD)),
                             2'($urandom_range(3)));
            else
                send_request(2'($urandom_range(3)), 16'($urandom), 4'($urandom_range(15)),
                             2'($urandom_range(3)));
        end
    endtask

    initial
    begin
        sb = new();
        sent = 0;
        tx_idle = 13;
        rx_idle = 75;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // no frames managed yet
        send_request(CMD_FREE, 16'd0, 4'd0, 2'd0);
        send_request(CMD_DONATE, 16'd0, 4'd0, 2'd0);
        send_request(CMD_ALLOC, 16'd0, 4'd0, 2'd3);
        send_request(CMD_STATS, 16'd0, 4'd0, 2'd0);
        drain();

        set_zones(17'd65536, 17'd4000, 17'd16384);
        send_request(CMD_STATS, 16'hffff, 4'd0, 2'd3);
        send_request(CMD_ALLOC, 16'd0, 4'd0, 2'd2);
        send_request(CMD_ALLOC, 16'd0, 4'd15, 2'd0);
        send_request(CMD_STATS, 16'd0, 4'd11, 2'd1);
        send_request(CMD_DONATE, 16'd3, 4'd2, 2'd0);
        send_request(CMD_DONATE, 16'd3584, 4'd9, 2'd0);
        send_request(CMD_DONATE, 16'd0, 4'd10, 2'd0);
        send_request(CMD_DONATE, 16'd1024, 4'd10, 2'd0);
        send_request(CMD_DONATE, 16'd65535, 4'd0, 2'd2);
        send_request(CMD_DONATE, 16'd16384, 4'd10, 2'd2);
        send_request(CMD_ALLOC, 16'd0, 4'd0, 2'd3);
        send_request(CMD_ALLOC, 16'd0, 4'd3, 2'd3);
        send_request(CMD_ALLOC, 16'd0, 4'd10, 2'd1);
        send_request(CMD_STATS, 16'd0, 4'd10, 2'd0);
        send_request(CMD_FREE, 16'd65535, 4'd0, 2'd0);
        send_request(CMD_FREE, 16'd16384, 4'd3, 2'd0);
        send_request(CMD_FREE, 16'd0, 4'd10, 2'd0);
        send_request(CMD_STATS, 16'd0, 4'd9, 2'd2);
        send_request(CMD_STATS, 16'd0, 4'd10, 2'd3);
        random_requests(130);
        drain();

        tx_idle = 75;
        rx_idle = 13;
        set_zones(17'd2048, 17'd0, 17'd1024);
        random_requests(150);
        drain();

        tx_idle = 0;
        rx_idle = 0;
        set_zones(17'd65536, 17'd65536, 17'd65536);
        random_requests(150);
        drain();

        set_zones(17'd40000, 17'd1000, 17'd30000);
        random_requests(150);
        drain();

        $display("%0d requests sent over four zone layouts, %0d responses checked",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.rsp_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/zbpa_pkg.sv
rtl/zbpa_frame_store.sv
rtl/zoned_buddy_page_allocator.sv
sim/testbench.sv
